// ----- rtl/core/sha1bs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1bs_pkg
// Shared types, constants and round functions of the SHA-1 byte stream core.
// ----------------------------------------------------------------------------
package sha1bs_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic push;    // a byte enters the word packer
        logic pack;    // that byte completes a 32-bit word
        logic step;    // one compression round advances the schedule
        logic expand;  // round 16 and later: schedule word is computed
    } t_sched_ctl;

    typedef logic [4:0][31:0] t_vars;

    localparam logic       CMD_ABSORB  = 1'b0;
    localparam logic       CMD_FINISH  = 1'b1;
    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [6:0] LAST_ROUND  = 7'd79;
    localparam logic [5:0] FILL_LAST   = 6'd63;
    localparam logic [5:0] FILL_PRELEN = 6'd55;
    localparam logic [2:0] DIGEST_LAST = 3'd4;

    localparam t_vars INIT_VECTOR = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam logic [31:0] K_CH  = 32'h5a827999;
    localparam logic [31:0] K_P1  = 32'h6ed9eba1;
    localparam logic [31:0] K_MAJ = 32'h8f1bbcdc;
    localparam logic [31:0] K_P2  = 32'hca62c1d6;

    function automatic logic [31:0] f_round_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < 7'd20) begin
            k = K_CH;
        end else if (t < 7'd40) begin
            k = K_P1;
        end else if (t < 7'd60) begin
            k = K_MAJ;
        end else begin
            k = K_P2;
        end
        return k;
    endfunction

    function automatic logic [31:0] f_round_f(input logic [6:0] t, input logic [31:0] b,
                                              input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (t < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (t >= 7'd40 && t < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

// ----- rtl/core/sha1bs_sched.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1bs_sched
// Byte packer and 16-word message schedule shift line.
// ----------------------------------------------------------------------------
module sha1bs_sched
    import sha1bs_pkg::*;
(
    input  logic        i_clk,
    input  t_sched_ctl  i_ctl,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_w
);

    logic [23:0]      r_acc;
    logic [15:0][31:0] r_line;
    logic [31:0]      w_mix;
    logic [31:0]      w_shift_in;

    // Entry 0 is the oldest word, which is W[t-16] once expansion starts.
    assign w_mix = r_line[13] ^ r_line[8] ^ r_line[2] ^ r_line[0];
    assign o_w   = i_ctl.expand ? {w_mix[30:0], w_mix[31]} : r_line[0];

    always_comb begin
        w_shift_in = o_w;
        if (i_ctl.push) begin
            w_shift_in = {r_acc, i_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_acc <= {r_acc[15:0], i_byte};
        end
        if ((i_ctl.push && i_ctl.pack) || i_ctl.step) begin
            for (int i = 0; i < 15; i++) begin
                r_line[i] <= r_line[i + 1];
            end
            r_line[15] <= w_shift_in;
        end
    end

endmodule

// ----- rtl/core/sha1bs_round.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1bs_round
// Working variables a..e and the shared SHA-1 round unit, one round a cycle.
// ----------------------------------------------------------------------------
module sha1bs_round
    import sha1bs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_load,
    input  t_vars       i_init,
    input  logic        i_step,
    input  logic [6:0]  i_round,
    input  logic [31:0] i_w,
    output t_vars       o_vars
);

    t_vars       r_vars;
    logic [31:0] w_a_rot;
    logic [31:0] w_tmp;

    assign w_a_rot = {r_vars[0][26:0], r_vars[0][31:27]};
    assign w_tmp   = w_a_rot + f_round_f(i_round, r_vars[1], r_vars[2], r_vars[3])
                   + r_vars[4] + i_w + f_round_k(i_round);
    assign o_vars  = r_vars;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vars <= i_init;
        end else if (i_step) begin
            r_vars[4] <= r_vars[3];
            r_vars[3] <= r_vars[2];
            r_vars[2] <= {r_vars[1][1:0], r_vars[1][31:2]};
            r_vars[1] <= r_vars[0];
            r_vars[0] <= w_tmp;
        end
    end

endmodule

// ----- rtl/core/sha1_byte_stream_hasher_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_core
// SHA-1 over a byte stream: absorb bytes, finish to emit the 160-bit digest.
// ----------------------------------------------------------------------------
// The absorb beat that fills a 64-byte block starts the compression, which
// runs 80 rounds on one shared round unit, one round a cycle, and then folds
// the result into the chain value; input ready is low through the rounds
// and the fold. A finish beat feeds the padding bytes through
// the same byte path, one per cycle, up to the end of the block (a second
// block when the length field does not fit), with each compression as above,
// then presents the five digest words, most significant first, one beat each,
// and the core restarts for the next message.
module sha1_byte_stream_hasher_core
    import sha1bs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [7:0]  i_msg_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_state      r_state, n_state;
    logic [5:0]  r_fill;
    logic [60:0] r_bytes;
    logic [63:0] r_len;
    logic [6:0]  r_round;
    logic [2:0]  r_idx;
    t_vars       r_chain;
    logic        r_finish;
    logic        r_pad_first;
    logic        r_len_go;

    t_sched_ctl  w_ctl;
    logic [7:0]  w_byte;
    logic [31:0] w_w;
    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_load;
    t_vars       w_vars;

    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;

    always_comb begin
        n_state      = r_state;
        o_ready      = 1'b0;
        o_valid      = 1'b0;
        w_ctl        = '0;
        w_byte       = i_msg_byte;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (w_in_acc) begin
                    if (i_command == CMD_FINISH) begin
                        n_state = ST_PAD;
                    end else begin
                        w_ctl.push = 1'b1;
                        if (r_fill == FILL_LAST) begin
                            n_state = ST_ROUND;
                        end
                    end
                end
            end
            ST_PAD: begin
                w_ctl.push = 1'b1;
                if (r_pad_first) begin
                    w_byte = PAD_BYTE;
                end else if (r_len_go) begin
                    w_byte = r_len[63:56];
                end else begin
                    w_byte = '0;
                end
                if (r_fill == FILL_LAST) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                w_ctl.step   = 1'b1;
                w_ctl.expand = (r_round >= 7'd16);
                if (r_round == LAST_ROUND) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (r_finish && r_len_go) begin
                    n_state = ST_OUT;
                end else if (r_finish) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready && r_idx == DIGEST_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        w_ctl.pack = (r_fill[1:0] == 2'b11);
    end

    // The last byte of a block also loads the working variables.
    assign w_load = w_ctl.push && (r_fill == FILL_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_bytes     <= '0;
            r_round     <= '0;
            r_idx       <= '0;
            r_chain     <= INIT_VECTOR;
            r_finish    <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctl.push) begin
                r_fill <= r_fill + 6'd1;
            end
            if (r_state == ST_IDLE && w_in_acc) begin
                if (i_command == CMD_ABSORB) begin
                    r_bytes <= r_bytes + 61'd1;
                end else begin
                    r_finish    <= 1'b1;
                    r_pad_first <= 1'b1;
                    r_len_go    <= 1'b0;
                end
            end
            if (r_state == ST_PAD) begin
                r_pad_first <= 1'b0;
                // Once byte 55 is written, the remaining eight are the length.
                if (r_fill == FILL_PRELEN) begin
                    r_len_go <= 1'b1;
                end
            end
            if (w_load) begin
                r_round <= '0;
            end else if (r_state == ST_ROUND) begin
                r_round <= r_round + 7'd1;
            end
            if (r_state == ST_FOLD) begin
                for (int i = 0; i < 5; i++) begin
                    r_chain[i] <= r_chain[i] + w_vars[i];
                end
                r_idx <= '0;
            end
            if (w_out_acc) begin
                r_idx <= r_idx + 3'd1;
                if (r_idx == DIGEST_LAST) begin
                    r_chain  <= INIT_VECTOR;
                    r_fill   <= '0;
                    r_bytes  <= '0;
                    r_finish <= 1'b0;
                    r_len_go <= 1'b0;
                end
            end
        end
    end

    // Length field, shifted out most significant byte first.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_in_acc && i_command == CMD_FINISH) begin
            r_len <= {r_bytes, 3'b000};
        end else if (r_state == ST_PAD && !r_pad_first && r_len_go) begin
            r_len <= {r_len[55:0], 8'h00};
        end
    end

    sha1bs_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_byte (w_byte),
        .o_w    (w_w)
    );

    sha1bs_round u_round (
        .i_clk   (i_clk),
        .i_load  (w_load),
        .i_init  (r_chain),
        .i_step  (w_ctl.step),
        .i_round (r_round),
        .i_w     (w_w),
        .o_vars  (w_vars)
    );

    assign o_digest_word = r_chain[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == DIGEST_LAST);

    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input accepted while digest words are pending");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_word_index <= DIGEST_LAST))
        else $error("digest word index out of range");

    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_round == LAST_ROUND) |=> (r_state == ST_FOLD))
        else $error("compression did not fold after the last round");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_word) |=> (r_fill == '0 && r_bytes == '0
                                                 && r_state == ST_IDLE))
        else $error("message state not restarted after the digest");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SHA-1 byte stream hasher core.
// A short table of directed beats comes first. Three of its rows carry
// digests that are known by heart: the empty string twice and "abc". The
// random messages that follow have lengths that straddle the padding and
// block boundaries. Every other digest beat is scored against a SHA-1 model
// kept inside the bench. Both handshakes idle at random, and the sink once
// holds off long enough to back the core up.
// ----------------------------------------------------------------------------
module tb
    import sha1bs_pkg::*;
();

    localparam int ITEM_TARGET  = 410;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int MAX_REPORTS  = 10;
    localparam int DIRECTED_ROWS = 12;

    localparam logic [159:0] SHA1_IV =
        160'h67452301_efcdab89_98badcfe_10325476_c3d2e1f0;
    localparam logic [31:0]  RK_CH  = 32'h5a827999;
    localparam logic [31:0]  RK_P1  = 32'h6ed9eba1;
    localparam logic [31:0]  RK_MAJ = 32'h8f1bbcdc;
    localparam logic [31:0]  RK_P2  = 32'hca62c1d6;
    localparam logic [7:0]   SHA1_PAD = 8'h80;

    localparam logic [159:0] DIGEST_EMPTY =
        160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
    localparam logic [159:0] DIGEST_ABC =
        160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

    typedef struct packed {
        logic         cmd;
        logic [7:0]   data;
        logic         has_known;
        logic [159:0] known;
    } t_stim_row;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_beat;

    // Known digests sit on rows where the message is trivial; the rest are
    // scored by the model.
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{CMD_FINISH, 8'h00, 1'b1, DIGEST_EMPTY},
        '{CMD_FINISH, 8'hff, 1'b1, DIGEST_EMPTY},
        '{CMD_ABSORB, 8'h61, 1'b0, 160'h0},
        '{CMD_ABSORB, 8'h62, 1'b0, 160'h0},
        '{CMD_ABSORB, 8'h63, 1'b0, 160'h0},
        '{CMD_FINISH, 8'h00, 1'b1, DIGEST_ABC},
        '{CMD_ABSORB, 8'h00, 1'b0, 160'h0},
        '{CMD_ABSORB, 8'hff, 1'b0, 160'h0},
        '{CMD_FINISH, 8'ha5, 1'b0, 160'h0},
        '{CMD_ABSORB, 8'h80, 1'b0, 160'h0},
        '{CMD_ABSORB, 8'h7f, 1'b0, 160'h0},
        '{CMD_FINISH, 8'h01, 1'b0, 160'h0}
    };

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic        i_command  = CMD_ABSORB;
    logic [7:0]  i_msg_byte = 8'h00;
    logic        i_ready    = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    // Model state of the message in flight.
    logic [31:0] chain_h [5];
    logic [7:0]  blk_bytes [64];
    int          fill;
    logic [63:0] bit_count;

    t_digest_beat digest_q [$];

    int  sent_items      = 0;
    int  bytes_absorbed  = 0;
    int  messages_hashed = 0;
    int  words_checked   = 0;
    int  mismatches      = 0;
    int  idle_cycles     = 0;
    bit  tx_quiet        = 1'b0;
    bit  tx_pressure     = 1'b0;
    bit  hold_request    = 1'b0;

    sha1_byte_stream_hasher_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_msg_byte    (i_msg_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic restart_message();
        for (int k = 0; k < 5; k++) begin
            chain_h[k] = SHA1_IV[159 - 32 * k -: 32];
        end
        fill      = 0;
        bit_count = 64'd0;
    endtask

    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) begin
            w[i] = {blk_bytes[4 * i], blk_bytes[4 * i + 1],
                    blk_bytes[4 * i + 2], blk_bytes[4 * i + 3]};
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++) begin
            // The schedule rolls in place over a 16-word window.
            if (r >= 16) begin
                w[r % 16] = rol32(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^
                                  w[(r + 2) % 16] ^ w[r % 16], 1);
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = RK_CH;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = RK_P1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = RK_MAJ;
            end else begin
                f = b ^ c ^ d;
                k = RK_P2;
            end
            t = rol32(a, 5) + f + e + w[r % 16] + k;
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endtask

    // Offers one beat, waits for it to be taken, then advances the model.
    task automatic send_beat(input logic cmd, input logic [7:0] data,
                             input logic has_known, input logic [159:0] known);
        int           gap;
        logic [159:0] digest;
        t_digest_beat beat;
        if (sent_items % 24 == 0 && !tx_pressure) begin
            tx_quiet = ($urandom_range(0, 2) == 0);
        end
        gap = (tx_quiet || tx_pressure) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_msg_byte <= data;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent_items++;

        if (cmd == CMD_ABSORB) begin
            blk_bytes[fill] = data;
            fill++;
            bit_count += 64'd8;
            bytes_absorbed++;
            if (fill == 64) begin
                compress_block();
                fill = 0;
            end
        end else begin
            blk_bytes[fill] = SHA1_PAD;
            fill++;
            // No room left for the length field: close this block first.
            if (fill > 56) begin
                while (fill < 64) begin
                    blk_bytes[fill] = 8'h00;
                    fill++;
                end
                compress_block();
                fill = 0;
            end
            while (fill < 56) begin
                blk_bytes[fill] = 8'h00;
                fill++;
            end
            for (int k = 0; k < 8; k++) begin
                blk_bytes[56 + k] = bit_count[63 - 8 * k -: 8];
            end
            compress_block();
            digest = has_known ? known
                               : {chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
            for (int k = 0; k < 5; k++) begin
                beat.word  = digest[159 - 32 * k -: 32];
                beat.index = 3'(k);
                beat.last  = (k == 4);
                digest_q.push_back(beat);
            end
            restart_message();
            messages_hashed++;
        end
    endtask

    // Drops valid and lets every pending digest beat drain out.
    task automatic wait_for_digests();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (digest_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input t_digest_beat want);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t %s: expected word %h index %0d last %b, got word %h index %0d last %b",
                     $time, what, want.word, want.index, want.last,
                     o_digest_word, o_word_index, o_last_word);
        end
    endtask

    initial begin : stimulus
        int len;
        restart_message();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_beat(directed_rows[r].cmd, directed_rows[r].data,
                      directed_rows[r].has_known, directed_rows[r].known);
        end

        // Back-to-back short messages while the sink holds off, so the
        // output side fills and the core has to stall its input.
        tx_pressure  = 1'b1;
        hold_request = 1'b1;
        repeat (3) begin
            repeat (3) send_beat(CMD_ABSORB, 8'($urandom_range(0, 255)), 1'b0, 160'h0);
            send_beat(CMD_FINISH, 8'($urandom_range(0, 255)), 1'b0, 160'h0);
        end
        tx_pressure = 1'b0;
        wait_for_digests();

        // Mostly short messages, plus lengths around the 55/56 and 63/64 byte
        // edges of one and two blocks.
        while (sent_items < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(0, 12);
                6, 7, 8:          len = 54 + $urandom_range(0, 11);
                default:          len = 118 + $urandom_range(0, 12);
            endcase
            repeat (len) send_beat(CMD_ABSORB, 8'($urandom_range(0, 255)), 1'b0, 160'h0);
            send_beat(CMD_FINISH, 8'($urandom_range(0, 255)), 1'b0, 160'h0);
        end

        wait_for_digests();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d messages, %0d bytes absorbed, %0d digest words checked,",
                 messages_hashed, bytes_absorbed, words_checked);
        $display("including empty, padding-overflow and multi-block messages under backpressure.");
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : digest_sink
        int           gap;
        int           rx_count;
        bit           rx_quiet;
        t_digest_beat want;
        rx_count = 0;
        rx_quiet = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_count % 20 == 0) begin
                rx_quiet = ($urandom_range(0, 2) == 0);
            end
            if (hold_request) begin
                gap          = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                gap = rx_quiet ? 0 : $urandom_range(0, 17);
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            rx_count++;
            if (digest_q.size() == 0) begin
                note_mismatch("digest beat with nothing pending", '0);
            end else begin
                want = digest_q.pop_front();
                if (o_digest_word !== want.word || o_word_index !== want.index ||
                    o_last_word !== want.last) begin
                    note_mismatch("digest beat mismatch", want);
                end else begin
                    words_checked++;
                end
            end
        end
    end

    // Ends the run if no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles without a beat", idle_cycles);
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ----- sha1_byte_stream_hasher_core.f -----
rtl/core/sha1bs_pkg.sv
rtl/core/sha1bs_sched.sv
rtl/core/sha1bs_round.sv
rtl/core/sha1_byte_stream_hasher_core.sv
sim/tb.sv
